// File: hdl/pwmrf_pkg.sv
package pwmrf_pkg;

  // Field and register widths
  localparam int unsigned TICK_W   = 7;
  localparam int unsigned REPEAT_W = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 7;

  // Input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEATS     = 3'd4;

  // Register reset values
  localparam logic [TICK_W-1:0]   RST_LONG_PULSE  = 7'd20;
  localparam logic [TICK_W-1:0]   RST_SHORT_PULSE = 7'd4;
  localparam logic [TICK_W-1:0]   RST_START_HIGH  = 7'd2;
  localparam logic [TICK_W-1:0]   RST_START_LOW   = 7'd62;
  localparam logic [REPEAT_W-1:0] RST_REPEATS     = 5'd20;

  // Segment phases (code 3 is never entered and behaves as idle)
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HIGH = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LOW  = 2'd2;

  // Last data bit position; position 0 is the start symbol
  localparam logic [POS_W-1:0] POS_START    = 4'd0;
  localparam logic [POS_W-1:0] POS_LAST_BIT = 4'd8;

  // A duration written as zero counts as one tick
  function automatic logic [TICK_W-1:0] at_least_one_tick(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [REPEAT_W-1:0] at_least_one_rep(input logic [REPEAT_W-1:0] v);
    return (v == '0) ? REPEAT_W'(1) : v;
  endfunction

endpackage

// File: hdl/pwmrf_in_if.sv
interface pwmrf_in_if
  import pwmrf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] frame_byte;

  modport source (output valid, output opcode, output frame_byte, input ready);
  modport sink   (input valid, input opcode, input frame_byte, output ready);
endinterface

// File: hdl/pwmrf_out_if.sv
interface pwmrf_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic send_rejected;

  modport source (output valid, output line_level, output busy_res, output send_rejected,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input send_rejected,
                  output ready);
endinterface

// File: hdl/pwmrf_cfg_if.sv
interface pwmrf_cfg_if
  import pwmrf_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/pwm_rf_frame_transmitter_core.sv
// Pulse-width RF frame transmitter.
// in_ch  : one transaction per item. opcode tick advances the line by one tick,
//          opcode send, when idle, loads frame_byte and starts repeats frames.
// out_ch : exactly one result transaction per input transaction, in order:
//          line level for that tick, busy flag and a send-rejected flag.
// cfg_ch : register writes (index 0..4: long, short, start high, start low,
//          repeats); always ready, indexes beyond 4 are dropped. Write only
//          while no result is outstanding.
// Output: a result is presented in the cycle after its input is accepted.
// Throughput: one item per cycle. The line state update (counter decrement
//          and phase/bit step) fits between the input handshake and the
//          result register, so in_ch.ready stays high while the result
//          register is empty or being drained in the same cycle.
// Stall: when out_ch.ready is low with a result held, in_ch.ready drops and
//          the held result stays stable until taken.
// Reset (rst_n low, synchronous): block idle, no result pending, registers
//          back to their default durations (20/4/2/62 ticks, 20 repeats).
module pwm_rf_frame_transmitter_core
  import pwmrf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  pwmrf_in_if.sink     in_ch,
  pwmrf_out_if.source  out_ch,
  pwmrf_cfg_if.sink    cfg_ch
);

  // Configuration registers
  logic [TICK_W-1:0]   long_r, short_r, st_high_r, st_low_r;
  logic [REPEAT_W-1:0] repeats_cfg_r;

  // Line state
  logic [BYTE_W-1:0]   held_byte_r,  held_byte_nxt;
  logic [POS_W-1:0]    bit_pos_r,    bit_pos_nxt;
  logic [REPEAT_W-1:0] reps_left_r,  reps_left_nxt;
  logic [PHASE_W-1:0]  phase_r,      phase_nxt;
  logic [TICK_W-1:0]   ticks_left_r, ticks_left_nxt;

  // Result register
  logic out_valid_r;
  logic level_r, level_nxt;
  logic busy_r,  busy_nxt;
  logic rej_r,   rej_nxt;

  logic in_fire;
  logic busy;
  logic [POS_W-1:0]    pos_inc;
  logic [REPEAT_W-1:0] reps_dec;

  // Duration of one part of the symbol at a given position
  function automatic logic [TICK_W-1:0] part_len(
    input logic [POS_W-1:0]  pos,
    input logic [BYTE_W-1:0] byte_v,
    input logic              high_part,
    input logic [TICK_W-1:0] l_len,
    input logic [TICK_W-1:0] s_len,
    input logic [TICK_W-1:0] sh_len,
    input logic [TICK_W-1:0] sl_len
  );
    logic [POS_W-1:0] sh;
    logic             bit_v;
    logic             pick_long;
    sh        = POS_LAST_BIT - pos;
    bit_v     = byte_v[sh[2:0]];
    pick_long = bit_v ~^ high_part;
    if (pos == POS_START) begin
      return at_least_one_tick(high_part ? sh_len : sl_len);
    end
    return at_least_one_tick(pick_long ? l_len : s_len);
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign busy         = (phase_r == PH_HIGH) || (phase_r == PH_LOW);
  assign pos_inc      = bit_pos_r + POS_W'(1);
  assign reps_dec     = (reps_left_r != '0) ? reps_left_r - REPEAT_W'(1) : '0;

  // Next state and result for one item
  always_comb begin
    held_byte_nxt  = held_byte_r;
    bit_pos_nxt    = bit_pos_r;
    reps_left_nxt  = reps_left_r;
    phase_nxt      = phase_r;
    ticks_left_nxt = ticks_left_r;
    level_nxt      = 1'b0;
    busy_nxt       = 1'b0;
    rej_nxt        = 1'b0;
    if (in_ch.opcode == OP_SEND) begin
      busy_nxt = 1'b1;
      if (busy) begin
        level_nxt = (phase_r == PH_HIGH);
        rej_nxt   = 1'b1;
      end else begin
        held_byte_nxt  = in_ch.frame_byte;
        bit_pos_nxt    = POS_START;
        reps_left_nxt  = at_least_one_rep(repeats_cfg_r);
        phase_nxt      = PH_HIGH;
        ticks_left_nxt = at_least_one_tick(st_high_r);
      end
    end else if (busy) begin
      level_nxt = (phase_r == PH_HIGH);
      busy_nxt  = 1'b1;
      if (ticks_left_r > TICK_W'(1)) begin
        ticks_left_nxt = ticks_left_r - TICK_W'(1);
      end else if (phase_r == PH_HIGH) begin
        phase_nxt      = PH_LOW;
        ticks_left_nxt = part_len(bit_pos_r, held_byte_r, 1'b0,
                                  long_r, short_r, st_high_r, st_low_r);
      end else if (pos_inc != POS_START && pos_inc <= POS_LAST_BIT) begin
        bit_pos_nxt    = pos_inc;
        phase_nxt      = PH_HIGH;
        ticks_left_nxt = part_len(pos_inc, held_byte_r, 1'b1,
                                  long_r, short_r, st_high_r, st_low_r);
      end else begin
        // End of frame: repeat or go idle
        reps_left_nxt = reps_dec;
        bit_pos_nxt   = POS_START;
        if (reps_dec == '0) begin
          phase_nxt      = PH_IDLE;
          ticks_left_nxt = '0;
        end else begin
          phase_nxt      = PH_HIGH;
          ticks_left_nxt = at_least_one_tick(st_high_r);
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r        <= RST_LONG_PULSE;
      short_r       <= RST_SHORT_PULSE;
      st_high_r     <= RST_START_HIGH;
      st_low_r      <= RST_START_LOW;
      repeats_cfg_r <= RST_REPEATS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LONG_PULSE:  long_r        <= cfg_ch.data;
        REG_SHORT_PULSE: short_r       <= cfg_ch.data;
        REG_START_HIGH:  st_high_r     <= cfg_ch.data;
        REG_START_LOW:   st_low_r      <= cfg_ch.data;
        REG_REPEATS:     repeats_cfg_r <= cfg_ch.data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Line state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= '0;
      bit_pos_r    <= POS_START;
      reps_left_r  <= '0;
      phase_r      <= PH_IDLE;
      ticks_left_r <= '0;
    end else if (in_fire) begin
      held_byte_r  <= held_byte_nxt;
      bit_pos_r    <= bit_pos_nxt;
      reps_left_r  <= reps_left_nxt;
      phase_r      <= phase_nxt;
      ticks_left_r <= ticks_left_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      level_r <= level_nxt;
      busy_r  <= busy_nxt;
      rej_r   <= rej_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.line_level    = level_r;
  assign out_ch.busy_res      = busy_r;
  assign out_ch.send_rejected = rej_r;

endmodule
